[rtl/cpg_pkg.sv]
// Shared types and constants for the clamped pairwise gravity block.
// No dependencies.
`default_nettype none
package cpg_pkg;

    localparam int DATA_W  = 32;
    localparam int NUM_W   = 96;
    localparam int RSQ_W   = 65;
    localparam int LEN_W   = 33;
    localparam int PROD_W  = 64;

    localparam logic CFG_GRAV = 1'b0;
    localparam logic CFG_MAXF = 1'b1;

    typedef struct packed {
        logic signed [DATA_W-1:0] a_pos_x;
        logic signed [DATA_W-1:0] a_pos_y;
        logic signed [DATA_W-1:0] b_pos_x;
        logic signed [DATA_W-1:0] b_pos_y;
        logic        [DATA_W-1:0] mass_a;
        logic        [DATA_W-1:0] mass_b;
    } t_cpg_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] force_x;
        logic signed [DATA_W-1:0] force_y;
        logic                     coincident;
        logic                     clamped;
    } t_cpg_out;

    typedef struct packed {
        logic              valid;
        logic [NUM_W-1:0]  num;
        logic [RSQ_W-1:0]  rsq;
        logic [DATA_W-1:0] ax;
        logic [DATA_W-1:0] ay;
        logic              neg_x;
        logic              neg_y;
        logic              coin;
        logic              clamp;
    } t_cpg_front;

    typedef struct packed {
        logic [DATA_W-1:0] ax;
        logic [DATA_W-1:0] ay;
        logic              neg_x;
        logic              neg_y;
        logic              coin;
        logic              clamp;
        logic [RSQ_W-1:0]  rsq;
    } t_cpg_dside;

    typedef struct packed {
        logic [DATA_W-1:0] ax;
        logic [DATA_W-1:0] ay;
        logic              neg_x;
        logic              neg_y;
        logic              coin;
        logic              clamp;
        logic [DATA_W-1:0] mag;
    } t_cpg_sside;

    typedef struct packed {
        logic neg_x;
        logic coin;
        logic clamp;
    } t_cpg_xside;

endpackage
`default_nettype wire

[rtl/cpg_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Standalone; no package use.
`default_nettype none
module cpg_div #(
    parameter int NUM_W  = 96,
    parameter int DEN_W  = 65,
    parameter int Q_W    = 32,
    parameter int SIDE_W = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [DEN_W-1:0]  i_den,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [Q_W-1:0]         o_quo,
    output logic [SIDE_W-1:0]      o_side
);
    localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [NUM_W-1:0]  r_rem  [Q_W];
    logic [DEN_W-1:0]  r_den  [Q_W];
    logic [Q_W-1:0]    r_quo  [Q_W];
    logic [SIDE_W-1:0] r_side [Q_W];
    logic [Q_W-1:0]    r_vld;

    logic [NUM_W-1:0]  s_rem  [Q_W];
    logic [DEN_W-1:0]  s_den  [Q_W];
    logic [Q_W-1:0]    s_quo  [Q_W];
    logic [SIDE_W-1:0] s_side [Q_W];
    logic [Q_W-1:0]    s_vld;
    logic [NUM_W-1:0]  n_rem  [Q_W];
    logic [Q_W-1:0]    n_quo  [Q_W];

    always_comb begin
        logic [CW-1:0] trial;
        s_rem[0]  = i_num;
        s_den[0]  = i_den;
        s_quo[0]  = '0;
        s_side[0] = i_side;
        s_vld[0]  = i_valid;
        for (int s = 1; s < Q_W; s++) begin
            s_rem[s]  = r_rem[s-1];
            s_den[s]  = r_den[s-1];
            s_quo[s]  = r_quo[s-1];
            s_side[s] = r_side[s-1];
            s_vld[s]  = r_vld[s-1];
        end
        for (int s = 0; s < Q_W; s++) begin
            trial = CW'(s_den[s]) << (Q_W - 1 - s);
            if (trial <= CW'(s_rem[s])) begin
                n_rem[s] = NUM_W'(CW'(s_rem[s]) - trial);
                n_quo[s] = s_quo[s] | (Q_W'(1) << (Q_W - 1 - s));
            end else begin
                n_rem[s] = s_rem[s];
                n_quo[s] = s_quo[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= s_vld;
        end
        for (int s = 0; s < Q_W; s++) begin
            r_rem[s]  <= n_rem[s];
            r_den[s]  <= s_den[s];
            r_quo[s]  <= n_quo[s];
            r_side[s] <= s_side[s];
        end
    end

    assign o_valid = r_vld[Q_W-1];
    assign o_quo   = r_quo[Q_W-1];
    assign o_side  = r_side[Q_W-1];
endmodule
`default_nettype wire

[rtl/cpg_sqrt.sv]
// Pipelined integer square root (floor), one root bit per stage, with sideband.
// Standalone; no package use.
`default_nettype none
module cpg_sqrt #(
    parameter int IN_W   = 65,
    parameter int R_W    = 33,
    parameter int SIDE_W = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [IN_W-1:0]   i_val,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [R_W-1:0]         o_root,
    output logic [SIDE_W-1:0]      o_side
);
    localparam int TW = (IN_W > 2 * R_W) ? IN_W + 2 : 2 * R_W + 1;

    logic [IN_W-1:0]   r_rem  [R_W];
    logic [R_W-1:0]    r_root [R_W];
    logic [SIDE_W-1:0] r_side [R_W];
    logic [R_W-1:0]    r_vld;

    logic [IN_W-1:0]   s_rem  [R_W];
    logic [R_W-1:0]    s_root [R_W];
    logic [SIDE_W-1:0] s_side [R_W];
    logic [R_W-1:0]    s_vld;
    logic [IN_W-1:0]   n_rem  [R_W];
    logic [R_W-1:0]    n_root [R_W];

    // (root + 2^i)^2 - root^2 = root*2^(i+1) + 2^(2i)
    always_comb begin
        logic [TW-1:0] trial;
        s_rem[0]  = i_val;
        s_root[0] = '0;
        s_side[0] = i_side;
        s_vld[0]  = i_valid;
        for (int s = 1; s < R_W; s++) begin
            s_rem[s]  = r_rem[s-1];
            s_root[s] = r_root[s-1];
            s_side[s] = r_side[s-1];
            s_vld[s]  = r_vld[s-1];
        end
        for (int s = 0; s < R_W; s++) begin
            trial = (TW'(s_root[s]) << (R_W - s)) + (TW'(1) << (2 * (R_W - 1 - s)));
            if (trial <= TW'(s_rem[s])) begin
                n_rem[s]  = IN_W'(TW'(s_rem[s]) - trial);
                n_root[s] = s_root[s] | (R_W'(1) << (R_W - 1 - s));
            end else begin
                n_rem[s]  = s_rem[s];
                n_root[s] = s_root[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= s_vld;
        end
        for (int s = 0; s < R_W; s++) begin
            r_rem[s]  <= n_rem[s];
            r_root[s] <= n_root[s];
            r_side[s] <= s_side[s];
        end
    end

    assign o_valid = r_vld[R_W-1];
    assign o_root  = r_root[R_W-1];
    assign o_side  = r_side[R_W-1];
endmodule
`default_nettype wire

[rtl/cpg_front.sv]
// Front end: offsets, squared distance, G*mA*mB and the clamp compare, 7 stages.
// Depends on cpg_pkg.
`default_nettype none
module cpg_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire cpg_pkg::t_cpg_in     i_item,
    input  wire logic [31:0]          i_grav,
    input  wire logic [31:0]          i_maxf,
    output cpg_pkg::t_cpg_front       o_front
);
    import cpg_pkg::*;

    logic [6:0] r_vld;

    logic signed [DATA_W:0] r_s1_dx, r_s1_dy;
    logic [DATA_W-1:0]      r_s1_ma, r_s1_mb;

    logic [DATA_W-1:0] r_s2_ax, r_s2_ay, r_s2_mb;
    logic              r_s2_nx, r_s2_ny;
    logic [63:0]       r_s2_gm;

    logic [DATA_W-1:0] r_s3_ax, r_s3_ay;
    logic              r_s3_nx, r_s3_ny;
    logic [63:0]       r_s3_sx, r_s3_sy, r_s3_plo, r_s3_phi;

    logic [DATA_W-1:0] r_s4_ax, r_s4_ay;
    logic              r_s4_nx, r_s4_ny;
    logic [RSQ_W-1:0]  r_s4_rsq;
    logic [NUM_W-1:0]  r_s4_num;

    logic [DATA_W-1:0] r_s5_ax, r_s5_ay;
    logic              r_s5_nx, r_s5_ny, r_s5_coin, r_s5_top;
    logic [RSQ_W-1:0]  r_s5_rsq;
    logic [NUM_W-1:0]  r_s5_num;
    logic [63:0]       r_s5_q0, r_s5_q1;

    logic [DATA_W-1:0] r_s6_ax, r_s6_ay;
    logic              r_s6_nx, r_s6_ny, r_s6_coin;
    logic [RSQ_W-1:0]  r_s6_rsq;
    logic [NUM_W-1:0]  r_s6_num;
    logic [NUM_W:0]    r_s6_rm;

    t_cpg_front r_out;

    logic [DATA_W:0] n_s2_adx, n_s2_ady;

    always_comb begin
        n_s2_adx = r_s1_dx[DATA_W] ? 33'(-r_s1_dx) : 33'(r_s1_dx);
        n_s2_ady = r_s1_dy[DATA_W] ? 33'(-r_s1_dy) : 33'(r_s1_dy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[5:0], i_valid};
        end

        r_s1_dx <= 33'($signed({i_item.b_pos_x[31], i_item.b_pos_x}))
                 - 33'($signed({i_item.a_pos_x[31], i_item.a_pos_x}));
        r_s1_dy <= 33'($signed({i_item.b_pos_y[31], i_item.b_pos_y}))
                 - 33'($signed({i_item.a_pos_y[31], i_item.a_pos_y}));
        r_s1_ma <= i_item.mass_a;
        r_s1_mb <= i_item.mass_b;

        r_s2_ax <= n_s2_adx[DATA_W-1:0];
        r_s2_ay <= n_s2_ady[DATA_W-1:0];
        r_s2_nx <= r_s1_dx[DATA_W];
        r_s2_ny <= r_s1_dy[DATA_W];
        r_s2_gm <= 64'(i_grav) * 64'(r_s1_ma);
        r_s2_mb <= r_s1_mb;

        r_s3_ax  <= r_s2_ax;
        r_s3_ay  <= r_s2_ay;
        r_s3_nx  <= r_s2_nx;
        r_s3_ny  <= r_s2_ny;
        r_s3_sx  <= 64'(r_s2_ax) * 64'(r_s2_ax);
        r_s3_sy  <= 64'(r_s2_ay) * 64'(r_s2_ay);
        r_s3_plo <= 64'(r_s2_gm[31:0]) * 64'(r_s2_mb);
        r_s3_phi <= 64'(r_s2_gm[63:32]) * 64'(r_s2_mb);

        r_s4_ax  <= r_s3_ax;
        r_s4_ay  <= r_s3_ay;
        r_s4_nx  <= r_s3_nx;
        r_s4_ny  <= r_s3_ny;
        r_s4_rsq <= 65'(r_s3_sx) + 65'(r_s3_sy);
        r_s4_num <= 96'(r_s3_plo) + (96'(r_s3_phi) << 32);

        r_s5_ax   <= r_s4_ax;
        r_s5_ay   <= r_s4_ay;
        r_s5_nx   <= r_s4_nx;
        r_s5_ny   <= r_s4_ny;
        r_s5_rsq  <= r_s4_rsq;
        r_s5_num  <= r_s4_num;
        r_s5_coin <= (r_s4_rsq == '0);
        r_s5_q0   <= 64'(r_s4_rsq[31:0]) * 64'(i_maxf);
        r_s5_q1   <= 64'(r_s4_rsq[63:32]) * 64'(i_maxf);
        r_s5_top  <= r_s4_rsq[64];

        r_s6_ax   <= r_s5_ax;
        r_s6_ay   <= r_s5_ay;
        r_s6_nx   <= r_s5_nx;
        r_s6_ny   <= r_s5_ny;
        r_s6_rsq  <= r_s5_rsq;
        r_s6_num  <= r_s5_num;
        r_s6_coin <= r_s5_coin;
        r_s6_rm   <= 97'(r_s5_q0) + (97'(r_s5_q1) << 32)
                   + (r_s5_top ? (97'(i_maxf) << 64) : 97'(0));

        r_out.num   <= r_s6_num;
        r_out.rsq   <= r_s6_rsq;
        r_out.ax    <= r_s6_ax;
        r_out.ay    <= r_s6_ay;
        r_out.neg_x <= r_s6_nx;
        r_out.neg_y <= r_s6_ny;
        r_out.coin  <= r_s6_coin;
        r_out.clamp <= (97'(r_s6_num) > r_s6_rm);
        r_out.valid <= 1'b0;
    end

    always_comb begin
        o_front       = r_out;
        o_front.valid = r_vld[6];
    end
endmodule
`default_nettype wire

[rtl/clamped_pairwise_gravity_2d.sv]
// Top level: config registers, magnitude divider, square root, component dividers.
// Depends on cpg_pkg, cpg_front, cpg_div, cpg_sqrt.
//
// Fully pipelined: one transaction is taken every cycle and o_busy stays low.
// Each result passes through 7 front-end stages, 32 for
// the magnitude divider, 33 for the square root, 1 product stage, 32 for the
// component dividers and 1 output register. o_valid is a one-cycle strobe;
// the receiver cannot stall it. Write registers only when the pipe is empty.
`default_nettype none
module clamped_pairwise_gravity_2d #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire cpg_pkg::t_cpg_in  i_item,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic [31:0]       i_cfg_wdata,
    output logic                   o_valid,
    output cpg_pkg::t_cpg_out      o_result
);
    import cpg_pkg::*;

    localparam logic [31:0] GRAV_RST = 32'(64'd1 << FRAC_BITS);
    localparam logic [31:0] MAXF_RST = 32'(64'd500 << FRAC_BITS);

    logic [31:0] r_grav, r_maxf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav <= GRAV_RST;
            r_maxf <= MAXF_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRAV: r_grav <= i_cfg_wdata;
                CFG_MAXF: r_maxf <= i_cfg_wdata;
                default:  r_grav <= r_grav;
            endcase
        end
    end

    assign o_busy = 1'b0;

    t_cpg_front front;

    cpg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start && !o_busy),
        .i_item  (i_item),
        .i_grav  (r_grav),
        .i_maxf  (r_maxf),
        .o_front (front)
    );

    t_cpg_dside d_in, d_out;
    logic        d_vld;
    logic [31:0] d_quo;

    always_comb begin
        d_in.ax    = front.ax;
        d_in.ay    = front.ay;
        d_in.neg_x = front.neg_x;
        d_in.neg_y = front.neg_y;
        d_in.coin  = front.coin;
        d_in.clamp = front.clamp;
        d_in.rsq   = front.rsq;
    end

    cpg_div #(
        .NUM_W  (NUM_W),
        .DEN_W  (RSQ_W),
        .Q_W    (DATA_W),
        .SIDE_W ($bits(t_cpg_dside))
    ) u_mag_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front.valid),
        .i_num   (front.num),
        .i_den   (front.rsq),
        .i_side  (d_in),
        .o_valid (d_vld),
        .o_quo   (d_quo),
        .o_side  (d_out)
    );

    t_cpg_sside s_in, s_out;
    logic              s_vld;
    logic [LEN_W-1:0]  s_len;

    always_comb begin
        s_in.ax    = d_out.ax;
        s_in.ay    = d_out.ay;
        s_in.neg_x = d_out.neg_x;
        s_in.neg_y = d_out.neg_y;
        s_in.coin  = d_out.coin;
        s_in.clamp = d_out.clamp;
        s_in.mag   = d_out.clamp ? r_maxf : d_quo;
    end

    cpg_sqrt #(
        .IN_W   (RSQ_W),
        .R_W    (LEN_W),
        .SIDE_W ($bits(t_cpg_sside))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d_vld),
        .i_val   (d_out.rsq),
        .i_side  (s_in),
        .o_valid (s_vld),
        .o_root  (s_len),
        .o_side  (s_out)
    );

    logic              r_p_vld;
    logic [PROD_W-1:0] r_p_px, r_p_py;
    logic [LEN_W-1:0]  r_p_len;
    t_cpg_xside        r_p_xs;
    logic              r_p_ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= s_vld;
        end
        r_p_px       <= 64'(s_out.mag) * 64'(s_out.ax);
        r_p_py       <= 64'(s_out.mag) * 64'(s_out.ay);
        r_p_len      <= s_len;
        r_p_xs.neg_x <= s_out.neg_x;
        r_p_xs.coin  <= s_out.coin;
        r_p_xs.clamp <= s_out.clamp;
        r_p_ny       <= s_out.neg_y;
    end

    logic        x_vld, y_vld;
    logic [31:0] x_quo, y_quo;
    t_cpg_xside  x_side;
    logic        y_neg;

    cpg_div #(
        .NUM_W  (PROD_W),
        .DEN_W  (LEN_W),
        .Q_W    (DATA_W),
        .SIDE_W ($bits(t_cpg_xside))
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p_vld),
        .i_num   (r_p_px),
        .i_den   (r_p_len),
        .i_side  (r_p_xs),
        .o_valid (x_vld),
        .o_quo   (x_quo),
        .o_side  (x_side)
    );

    cpg_div #(
        .NUM_W  (PROD_W),
        .DEN_W  (LEN_W),
        .Q_W    (DATA_W),
        .SIDE_W (1)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p_vld),
        .i_num   (r_p_py),
        .i_den   (r_p_len),
        .i_side  (r_p_ny),
        .o_valid (y_vld),
        .o_quo   (y_quo),
        .o_side  (y_neg)
    );

    logic        r_out_vld;
    t_cpg_out    r_out;
    t_cpg_out    n_out;
    logic [31:0] n_fx, n_fy;

    always_comb begin
        if (x_side.neg_x) begin
            n_fx = (x_quo > 32'h8000_0000) ? 32'h8000_0000 : 32'(-x_quo);
        end else begin
            n_fx = (x_quo > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : x_quo;
        end
        if (y_neg) begin
            n_fy = (y_quo > 32'h8000_0000) ? 32'h8000_0000 : 32'(-y_quo);
        end else begin
            n_fy = (y_quo > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : y_quo;
        end
        if (x_side.coin) begin
            n_out.force_x    = '0;
            n_out.force_y    = '0;
            n_out.coincident = 1'b1;
            n_out.clamped    = 1'b0;
        end else begin
            n_out.force_x    = n_fx;
            n_out.force_y    = n_fy;
            n_out.coincident = 1'b0;
            n_out.clamped    = x_side.clamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= x_vld && y_vld;
        end
        r_out <= n_out;
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;
endmodule
`default_nettype wire
